// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/dbfr_pkg.sv -----
package dbfr_pkg;

   localparam int unsigned GAP_W = 16;
   localparam int unsigned CNT_W = 7;
   localparam int unsigned FRAME_BITS = 39;
   localparam int unsigned SEG_W = 7;
   localparam int unsigned CHAR_W = 7;
   localparam int unsigned STATUS_W = 11;
   localparam int unsigned STATUS_LSB = 28;
   localparam int unsigned TEMP_W = 10;

   localparam logic [CNT_W-1:0] LAST_DISPLAY_BIT = 7'd38;
   localparam logic [CNT_W-1:0] FRAME_END_COUNT = 7'd42;
   localparam logic [CNT_W-1:0] BTN_FIRST_COUNT = 7'd39;
   localparam logic [CNT_W-1:0] BTN_MID_COUNT = 7'd40;
   localparam logic [CNT_W-1:0] BTN_LAST_COUNT = 7'd41;
   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
   localparam logic [GAP_W-1:0] GAP_RESET = 16'd1000;

   localparam logic [2:0] BTN_NONE = 3'd0;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
   localparam logic [CHAR_W-1:0] ASCII_DASH = 7'h2D;

   // levels driven at counts 39, 40, 41 (bits 2, 1, 0)
   localparam logic [2:0] DRIVE_TABLE [8] = '{
      3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd6, 3'd2, 3'd7
   };

   typedef struct packed {
      logic             clock_level;
      logic             display_bit;
      logic [GAP_W-1:0] gap_us;
      logic [2:0]       button_request;
   } req_type;

   typedef struct packed {
      logic                  button_drive;
      logic                  frame_done;
      logic [4*SEG_W-1:0]    raw_segments;
      logic [CHAR_W-1:0]     char_one;
      logic [CHAR_W-1:0]     char_two;
      logic [CHAR_W-1:0]     char_three;
      logic [CHAR_W-1:0]     char_four;
      logic [STATUS_W-1:0]   status_bits;
      logic                  temp_shown;
      logic [TEMP_W-1:0]     temp_tenths;
      logic                  temp_is_setpoint;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic line_level;
      logic frame_done;
      logic overflow;
   } ctl_status_type;

   function automatic logic [CHAR_W-1:0] seg_to_ascii(input logic [SEG_W-1:0] code);
      logic [CHAR_W-1:0] c;
      unique case (code)
         7'h00: c = 7'h20;
         7'h7E: c = 7'h30;
         7'h30: c = 7'h31;
         7'h6D: c = 7'h32;
         7'h79: c = 7'h33;
         7'h33: c = 7'h34;
         7'h5B: c = 7'h35;
         7'h5F: c = 7'h36;
         7'h70: c = 7'h37;
         7'h7F: c = 7'h38;
         7'h73: c = 7'h39;
         7'h77: c = 7'h41;
         7'h4E: c = 7'h43;
         7'h4F: c = 7'h45;
         7'h5E: c = 7'h47;
         7'h37: c = 7'h48;
         7'h3C: c = 7'h4A;
         7'h0E: c = 7'h4C;
         7'h54: c = 7'h4D;
         7'h76: c = 7'h4E;
         7'h6B: c = 7'h51;
         7'h66: c = 7'h52;
         7'h3E: c = 7'h55;
         7'h2A: c = 7'h57;
         7'h7D: c = 7'h61;
         7'h1F: c = 7'h62;
         7'h0D: c = 7'h63;
         7'h3D: c = 7'h64;
         7'h6F: c = 7'h65;
         7'h47: c = 7'h66;
         7'h17: c = 7'h68;
         7'h04: c = 7'h69;
         7'h01: c = 7'h6A;
         7'h57: c = 7'h6B;
         7'h06: c = 7'h6C;
         7'h14: c = 7'h6D;
         7'h15: c = 7'h6E;
         7'h1D: c = 7'h6F;
         7'h67: c = 7'h70;
         7'h05: c = 7'h72;
         7'h0F: c = 7'h74;
         7'h1C: c = 7'h75;
         7'h3B: c = 7'h79;
         default: c = ASCII_DASH;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [3:0] d;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         d = c[3:0];
      end else begin
         d = 4'd0;
      end
      return d;
   endfunction

endpackage

// ----- rtl/dbfr_in_stage.sv -----
module dbfr_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dbfr_pkg::req_type req_data,
   input  logic              advance,
   output logic              item_valid,
   output dbfr_pkg::req_type item_data
);
   import dbfr_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    take;

   assign req_stall = valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data = data_ff;
endmodule

// ----- rtl/dbfr_frame_ctl.sv -----
module dbfr_frame_ctl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dbfr_pkg::GAP_W-1:0]        csr_wr_data,
   input  logic                              step,
   input  dbfr_pkg::req_type                 item_data,
   output dbfr_pkg::ctl_status_type          status,
   output logic [dbfr_pkg::FRAME_BITS-1:0]   frame_bits
);
   import dbfr_pkg::*;

   logic [GAP_W-1:0]      gap_cfg_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] bits_ff, bits_in;
   logic [2:0]            pend_ff, pend_in;
   logic                  line_ff, line_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      cnt;
   logic [2:0]            pend;
   logic [2:0]            drive;
   logic                  done;

   always_comb begin
      pend = (item_data.button_request != BTN_NONE) ? item_data.button_request : pend_ff;
      cnt = (item_data.gap_us >= gap_cfg_ff) ? '0 : count_ff;
      drive = DRIVE_TABLE[pend];
      pend_in = pend;
      line_in = line_ff;
      bits_in = bits_ff;
      ovf_in = ovf_ff;
      count_in = cnt;
      done = 1'b0;
      if (!item_data.clock_level) begin
         line_in = 1'b0;
      end else begin
         if (pend != BTN_NONE) begin
            priority if (cnt == BTN_FIRST_COUNT) begin
               line_in = drive[2];
            end else if (cnt == BTN_MID_COUNT) begin
               line_in = drive[1];
            end else if (cnt == BTN_LAST_COUNT) begin
               line_in = drive[0];
               pend_in = BTN_NONE;
            end else begin
               line_in = line_ff;
            end
         end
         for (int i = 0; i < FRAME_BITS; i++) begin
            if (cnt == CNT_W'(i)) begin
               bits_in[i] = item_data.display_bit;
            end
         end
         priority if (cnt == FRAME_END_COUNT) begin
            done = 1'b1;
         end else if (cnt > FRAME_END_COUNT) begin
            ovf_in = 1'b1;
         end else begin
            done = 1'b0;
         end
         if (cnt != CNT_MAX) begin
            count_in = cnt + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_cfg_ff <= GAP_RESET;
      end else if (csr_wr_en) begin
         gap_cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bits_ff <= '0;
         pend_ff <= BTN_NONE;
         line_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         bits_ff <= bits_in;
         pend_ff <= pend_in;
         line_ff <= line_in;
         ovf_ff <= ovf_in;
      end
   end

   assign status.line_level = line_in;
   assign status.frame_done = done;
   assign status.overflow = ovf_in;
   assign frame_bits = bits_ff;
endmodule

// ----- rtl/dbfr_decode.sv -----
module dbfr_decode (
   input  dbfr_pkg::ctl_status_type        status,
   input  logic [dbfr_pkg::FRAME_BITS-1:0] frame_bits,
   output dbfr_pkg::rsp_type               result
);
   import dbfr_pkg::*;

   logic [SEG_W-1:0]  seg [4];
   logic [CHAR_W-1:0] chr [4];
   logic [TEMP_W-1:0] tenths;
   logic              shown;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < SEG_W; k++) begin
            seg[c][SEG_W-1-k] = frame_bits[SEG_W*c+k];
         end
         chr[c] = seg_to_ascii(seg[c]);
      end
      shown = (seg[0] != '0);
      tenths = TEMP_W'({6'd0, digit_value(chr[0])} * 10'd100)
             + TEMP_W'({6'd0, digit_value(chr[1])} * 10'd10)
             + TEMP_W'(digit_value(chr[2]));
   end

   always_comb begin
      result = '0;
      result.button_drive = status.line_level;
      result.frame_done = status.frame_done;
      result.overflow = status.overflow;
      if (status.frame_done) begin
         result.raw_segments = {seg[0], seg[1], seg[2], seg[3]};
         result.char_one = chr[0];
         result.char_two = chr[1];
         result.char_three = chr[2];
         result.char_four = chr[3];
         result.status_bits = frame_bits[STATUS_LSB +: STATUS_W];
         result.temp_shown = shown;
         if (shown) begin
            result.temp_tenths = tenths;
            result.temp_is_setpoint = frame_bits[STATUS_LSB];
         end
      end
   end
endmodule

// ----- rtl/dbfr_out_stage.sv -----
module dbfr_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  dbfr_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dbfr_pkg::rsp_type rsp_data
);
   import dbfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign advance = item_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      priority if (advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;
endmodule

// ----- rtl/display_bus_frame_receiver_core.sv -----
// Receives a serial display bus one clock edge per item and returns one result per item.
// An item can be taken every cycle unless the result is stalled; its result is loaded into
// the result register when the item leaves the input register, so the path is the input
// register and the result register around a single pass of update and segment decoding.
// A stalled result holds while one further item waits in the input register. The gap
// register (reset 1000 us) should only be written while no item is in flight.
module display_bus_frame_receiver_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  dbfr_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output dbfr_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [dbfr_pkg::GAP_W-1:0] csr_wr_data
);
   import dbfr_pkg::*;

   logic                  advance;
   logic                  item_valid;
   req_type               item_data;
   ctl_status_type        status;
   logic [FRAME_BITS-1:0] frame_bits;
   rsp_type               result;

   dbfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   dbfr_frame_ctl u_frame_ctl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item_data   (item_data),
      .status      (status),
      .frame_bits  (frame_bits)
   );

   dbfr_decode u_decode (
      .status     (status),
      .frame_bits (frame_bits),
      .result     (result)
   );

   dbfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );
endmodule

// ----- rtl/dbfr_checker.sv -----
`include "assert_macros.svh"

module dbfr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dbfr_pkg::rsp_type rsp_data
);
   import dbfr_pkg::*;

   logic rsp_take;
   logic seen_ovf_ff, seen_ovf_in;
   logic idle_clear;
   logic temp_clear;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign seen_ovf_in = seen_ovf_ff || (rsp_take && rsp_data.overflow);
   assign idle_clear = (rsp_data.raw_segments == '0) && (rsp_data.status_bits == '0)
                       && !rsp_data.temp_shown;
   assign temp_clear = (rsp_data.temp_tenths == '0) && !rsp_data.temp_is_setpoint;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ovf_ff <= 1'b0;
      end else begin
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   `ASSERT_IMPLY(a_ovf_sticky, clock, reset, rsp_take && seen_ovf_ff, rsp_data.overflow)
   `ASSERT_IMPLY(a_idle_fields, clock, reset, rsp_valid && !rsp_data.frame_done, idle_clear)
   `ASSERT_IMPLY(a_no_temp, clock, reset, rsp_valid && !rsp_data.temp_shown, temp_clear)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule

bind display_bus_frame_receiver_core dbfr_checker u_checker (.*);

// ----- verif/display_bus_frame_receiver_core_test.sv -----
`timescale 1ns / 1ps

module display_bus_frame_receiver_core_test;

   typedef enum logic [2:0] {
      BUTTON_NONE, BUTTON_MODE, BUTTON_UP, BUTTON_DOWN,
      BUTTON_LIGHT, BUTTON_PUMP1, BUTTON_PUMP2, BUTTON_PUMP3
   } button_code_type;

   localparam int SETTLE_CYCLES = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   dbfr_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   dbfr_pkg::rsp_type   rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [15:0]         csr_wr_data = '0;

   // receiver state as seen by the checker
   logic [15:0]         gap_limit = 16'd1000;
   logic [6:0]          bit_pos = '0;
   logic [38:0]         frame_reg = '0;
   logic [2:0]          held_button = BUTTON_NONE;
   logic                line_high = 1'b0;
   logic                overflow_seen = 1'b0;

   dbfr_pkg::req_type   bus_edges [$];
   dbfr_pkg::rsp_type   awaited_readouts [$];
   int                  sent_count = 0;
   int                  checked_count = 0;
   int                  fail_count = 0;
   int                  send_idle = 0;
   int                  stall_left = 0;
   bit                  steady_run = 1'b0;

   display_bus_frame_receiver_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] char_of(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'h00: ch = " ";
         7'h7E: ch = "0";
         7'h30: ch = "1";
         7'h6D: ch = "2";
         7'h79: ch = "3";
         7'h33: ch = "4";
         7'h5B: ch = "5";
         7'h5F: ch = "6";
         7'h70: ch = "7";
         7'h7F: ch = "8";
         7'h73: ch = "9";
         7'h77: ch = "A";
         7'h4E: ch = "C";
         7'h4F: ch = "E";
         7'h5E: ch = "G";
         7'h37: ch = "H";
         7'h3C: ch = "J";
         7'h0E: ch = "L";
         7'h54: ch = "M";
         7'h76: ch = "N";
         7'h6B: ch = "Q";
         7'h66: ch = "R";
         7'h3E: ch = "U";
         7'h2A: ch = "W";
         7'h7D: ch = "a";
         7'h1F: ch = "b";
         7'h0D: ch = "c";
         7'h3D: ch = "d";
         7'h6F: ch = "e";
         7'h47: ch = "f";
         7'h17: ch = "h";
         7'h04: ch = "i";
         7'h01: ch = "j";
         7'h57: ch = "k";
         7'h06: ch = "l";
         7'h14: ch = "m";
         7'h15: ch = "n";
         7'h1D: ch = "o";
         7'h67: ch = "p";
         7'h05: ch = "r";
         7'h0F: ch = "t";
         7'h1C: ch = "u";
         7'h3B: ch = "y";
         default: ch = "-";
      endcase
      return ch;
   endfunction

   function automatic int digit_of(input logic [7:0] ch);
      int d;
      d = 0;
      if (ch >= "0" && ch <= "9") begin
         d = int'(ch) - int'("0");
      end
      return d;
   endfunction

   // levels on the return line at counts 39, 40, 41 (bits 2, 1, 0)
   function automatic logic [2:0] button_pattern(input logic [2:0] code);
      logic [2:0] p;
      case (code)
         BUTTON_MODE:  p = 3'd1;
         BUTTON_UP:    p = 3'd4;
         BUTTON_DOWN:  p = 3'd5;
         BUTTON_LIGHT: p = 3'd3;
         BUTTON_PUMP1: p = 3'd6;
         BUTTON_PUMP2: p = 3'd2;
         BUTTON_PUMP3: p = 3'd7;
         default:      p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic dbfr_pkg::rsp_type step_receiver(input dbfr_pkg::req_type e);
      dbfr_pkg::rsp_type r;
      logic [27:0]       segs;
      logic [7:0]        chars [4];
      logic [2:0]        pattern;
      int                k;
      int                tenths;
      r = '0;
      segs = '0;
      if (e.button_request != BUTTON_NONE) begin
         held_button = e.button_request;
      end
      if (e.gap_us >= gap_limit) begin
         bit_pos = '0;
      end
      if (!e.clock_level) begin
         line_high = 1'b0;
      end else begin
         if (held_button != BUTTON_NONE && bit_pos >= dbfr_pkg::BTN_FIRST_COUNT &&
             bit_pos <= dbfr_pkg::BTN_LAST_COUNT) begin
            pattern = button_pattern(held_button);
            line_high = pattern[int'(dbfr_pkg::BTN_LAST_COUNT) - int'(bit_pos)];
            if (bit_pos == dbfr_pkg::BTN_LAST_COUNT) begin
               held_button = BUTTON_NONE;
            end
         end
         if (bit_pos <= dbfr_pkg::LAST_DISPLAY_BIT) begin
            frame_reg[bit_pos] = e.display_bit;
         end else if (bit_pos == dbfr_pkg::FRAME_END_COUNT) begin
            r.frame_done = 1'b1;
         end else if (bit_pos > dbfr_pkg::FRAME_END_COUNT) begin
            overflow_seen = 1'b1;
         end
         if (bit_pos != dbfr_pkg::CNT_MAX) begin
            bit_pos = bit_pos + 7'd1;
         end
      end
      r.button_drive = line_high;
      if (r.frame_done) begin
         for (k = 0; k < 28; k++) begin
            segs[27-k] = frame_reg[k];
         end
         for (k = 0; k < 4; k++) begin
            chars[k] = char_of(segs[27-7*k -: 7]);
         end
         r.raw_segments = segs;
         r.char_one = chars[0][6:0];
         r.char_two = chars[1][6:0];
         r.char_three = chars[2][6:0];
         r.char_four = chars[3][6:0];
         r.status_bits = frame_reg[38:28];
         if (segs[27:21] != '0) begin
            tenths = 100 * digit_of(chars[0]) + 10 * digit_of(chars[1]) + digit_of(chars[2]);
            r.temp_shown = 1'b1;
            r.temp_tenths = 10'(tenths);
            r.temp_is_setpoint = frame_reg[28];
         end
      end
      r.overflow = overflow_seen;
      return r;
   endfunction

   function automatic int pick_pause();
      int roll;
      int len;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         steady_run = !steady_run;
      end
      if (steady_run || roll < 50) begin
         len = 0;
      end else if (roll < 85) begin
         len = $urandom_range(1, 3);
      end else if (roll < 97) begin
         len = $urandom_range(4, 12);
      end else begin
         len = $urandom_range(20, 60);
      end
      return len;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_readouts.push_back(step_receiver(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (bus_edges.size() > 0) begin
               req_data <= bus_edges.pop_front();
               req_valid <= 1'b1;
               send_idle = pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      dbfr_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (awaited_readouts.size() == 0) begin
               fail_count++;
               $display("%0t unexpected readout: expected none, got %h", $time, rsp_data);
            end else begin
               want = awaited_readouts.pop_front();
               check_field("button_drive", 32'(want.button_drive), 32'(rsp_data.button_drive));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_data.frame_done));
               check_field("raw_segments", 32'(want.raw_segments), 32'(rsp_data.raw_segments));
               check_field("char_one", 32'(want.char_one), 32'(rsp_data.char_one));
               check_field("char_two", 32'(want.char_two), 32'(rsp_data.char_two));
               check_field("char_three", 32'(want.char_three), 32'(rsp_data.char_three));
               check_field("char_four", 32'(want.char_four), 32'(rsp_data.char_four));
               check_field("status_bits", 32'(want.status_bits), 32'(rsp_data.status_bits));
               check_field("temp_shown", 32'(want.temp_shown), 32'(rsp_data.temp_shown));
               check_field("temp_tenths", 32'(want.temp_tenths), 32'(rsp_data.temp_tenths));
               check_field("temp_is_setpoint", 32'(want.temp_is_setpoint),
                           32'(rsp_data.temp_is_setpoint));
               check_field("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) begin
               stall_left = pick_pause();
            end
         end
      end
   end

   task automatic push_edge(input logic level, input logic dbit, input logic [15:0] gap,
                            input logic [2:0] button);
      dbfr_pkg::req_type e;
      e.clock_level = level;
      e.display_bit = dbit;
      e.gap_us = gap;
      e.button_request = button;
      bus_edges.push_back(e);
      sent_count++;
   endtask

   function automatic logic [15:0] start_gap();
      logic [15:0] g;
      if ($urandom_range(0, 1) == 0) begin
         g = gap_limit;
      end else begin
         g = 16'($urandom_range(int'(gap_limit), 65535));
      end
      return g;
   endfunction

   function automatic logic [15:0] short_gap();
      int top;
      logic [15:0] g;
      top = int'(gap_limit) - 1;
      if (top < 0) begin
         g = '0;
      end else if ($urandom_range(0, 9) < 7) begin
         g = 16'($urandom_range(0, (top < 100) ? top : 100));
      end else begin
         g = 16'($urandom_range(0, top));
      end
      return g;
   endfunction

   function automatic logic [38:0] build_frame(input logic [6:0] c1, input logic [6:0] c2,
                                               input logic [6:0] c3, input logic [6:0] c4,
                                               input logic [10:0] status);
      logic [38:0] f;
      logic [27:0] segs;
      int k;
      segs = {c1, c2, c3, c4};
      for (k = 0; k < 28; k++) begin
         f[k] = segs[27-k];
      end
      f[38:28] = status;
      return f;
   endfunction

   function automatic logic [6:0] random_segment();
      logic [6:0] code;
      logic [7:0] ch;
      int kind;
      kind = $urandom_range(0, 9);
      code = 7'($urandom_range(0, 127));
      ch = char_of(code);
      if (kind < 5) begin
         while (!(ch >= "0" && ch <= "9")) begin
            code = 7'($urandom_range(0, 127));
            ch = char_of(code);
         end
      end else if (kind < 8) begin
         while (ch == "-") begin
            code = 7'($urandom_range(0, 127));
            ch = char_of(code);
         end
      end else if (kind == 8) begin
         code = '0;
      end
      return code;
   endfunction

   // one frame of rising edges with optional falling edges between them and after the last
   task automatic queue_frame(input logic [38:0] bits, input int rises, input int button_at,
                              input logic [2:0] button);
      int r;
      logic [2:0] b;
      logic dbit;
      for (r = 0; r < rises; r++) begin
         if (r > 0 && $urandom_range(0, 3) != 0) begin
            push_edge(1'b0, 1'($urandom), short_gap(), BUTTON_NONE);
         end
         if (r == button_at) begin
            b = button;
         end else if ($urandom_range(0, 15) == 0) begin
            b = 3'($urandom_range(1, 7));
         end else begin
            b = BUTTON_NONE;
         end
         if (r <= 38) begin
            dbit = bits[r];
         end else begin
            dbit = 1'($urandom);
         end
         push_edge(1'b1, dbit, (r == 0) ? start_gap() : short_gap(), b);
      end
      if ($urandom_range(0, 1) == 0) begin
         push_edge(1'b0, 1'($urandom), short_gap(), BUTTON_NONE);
      end
   endtask

   task automatic queue_noise(input int count);
      int n;
      logic [15:0] g;
      logic [2:0] b;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(0, 2))
            0: g = 16'($urandom_range(0, 65535));
            1: g = 16'($urandom_range(int'(gap_limit) > 0 ? int'(gap_limit) - 1 : 0,
                                      int'(gap_limit) < 65535 ? int'(gap_limit) + 1 : 65535));
            default: g = short_gap();
         endcase
         b = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'(BUTTON_NONE);
         push_edge(1'($urandom), 1'($urandom), g, b);
      end
   endtask

   task automatic settle();
      while (checked_count != sent_count) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap_limit(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gap_limit = value;
   endtask

   task automatic random_phase(input int count);
      int first;
      int roll;
      int button_at;
      logic [2:0] button;
      logic [38:0] bits;
      first = sent_count;
      while (sent_count - first < count) begin
         roll = $urandom_range(0, 9);
         bits = build_frame(random_segment(), random_segment(), random_segment(),
                            random_segment(), 11'($urandom));
         button_at = -1;
         button = BUTTON_NONE;
         if ($urandom_range(0, 2) == 0) begin
            button_at = $urandom_range(36, 42);
            button = 3'($urandom_range(1, 7));
         end
         if (roll < 7) begin
            queue_frame(bits, 43, button_at, button);
         end else if (roll == 7) begin
            queue_frame(bits, $urandom_range(44, 50), button_at, button);
         end else if (roll == 8) begin
            queue_frame(bits, $urandom_range(1, 42), button_at, button);
         end else begin
            queue_noise($urandom_range(1, 8));
         end
      end
      settle();
   endtask

   initial begin
      button_code_type code;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes of single items under the reset gap setting
      push_edge(1'b1, 1'b1, 16'd0, BUTTON_NONE);
      push_edge(1'b0, 1'b0, 16'hFFFF, BUTTON_NONE);
      push_edge(1'b1, 1'b0, 16'hFFFF, BUTTON_NONE);
      code = code.first();
      do begin
         push_edge(1'b0, 1'b1, 16'd5, code);
         code = code.next();
      end while (code != code.first());

      // temperature 123 as set point, button already pending
      queue_frame(build_frame(7'h30, 7'h6D, 7'h79, 7'h4E, 11'h001), 43, -1, BUTTON_NONE);
      // blank first character, request arriving in the middle of the code
      queue_frame(build_frame(7'h00, 7'h7F, 7'h7C, 7'h7F, 11'h7FE), 43, 40, BUTTON_UP);
      // non-digit characters inside the temperature
      queue_frame(build_frame(7'h73, 7'h2A, 7'h0E, 7'h00, 11'h554), 43, 39, BUTTON_LIGHT);
      // edges past the frame end
      queue_frame(build_frame(7'h7E, 7'h7E, 7'h7E, 7'h7E, 11'h2AA), 46, 41, BUTTON_PUMP1);
      // counter saturation, carrying on from the frame above
      for (n = 0; n < 85; n++) begin
         push_edge(1'b1, 1'($urandom), 16'd0, BUTTON_NONE);
      end
      settle();

      write_gap_limit(16'hFFFF);
      random_phase(30);
      write_gap_limit(16'($urandom_range(2, 500)));
      random_phase(30);
      write_gap_limit(16'd0);
      random_phase(10);
      write_gap_limit(16'd1);
      random_phase(10);
      write_gap_limit(16'd1000);
      random_phase(30);

      if (awaited_readouts.size() != 0) begin
         fail_count++;
         $display("%0t missing readouts: expected %0d more, got none",
                  $time, awaited_readouts.size());
      end
      if (fail_count == 0) begin
         $display("display_bus_frame_receiver_core_test: PASS");
      end else begin
         $display("display_bus_frame_receiver_core_test: FAIL");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("display_bus_frame_receiver_core_test: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dbfr_pkg.sv
rtl/dbfr_in_stage.sv
rtl/dbfr_frame_ctl.sv
rtl/dbfr_decode.sv
rtl/dbfr_out_stage.sv
rtl/display_bus_frame_receiver_core.sv
rtl/dbfr_checker.sv
verif/display_bus_frame_receiver_core_test.sv
